// File: hdl/dctt_pkg.sv
// ----------------------------------------------------------------------------
// Delayed call timer table package
// Field widths, codes and the control word shared by the timer table modules.
// ----------------------------------------------------------------------------
package dctt_pkg;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned HANDLE_W  = 16;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 16;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TICK   = 2'd2
  } action_e;

  typedef enum logic {
    KIND_FIRED = 1'b0,
    KIND_FULL  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic pop;
    logic push;
  } chain_ctl_t;

endpackage

// File: hdl/dctt_cell.sv
// ----------------------------------------------------------------------------
// Timer table cell
// Holds one table entry; takes its neighbor's entry on a pop, or the new entry
// when it is the write position of a push.
// ----------------------------------------------------------------------------
module dctt_cell
  import dctt_pkg::*;
#(
  parameter int unsigned INDEX       = 0,
  parameter int unsigned IDX_W       = 6,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                   clk_i,
  input  chain_ctl_t             ctl_i,
  input  logic [IDX_W-1:0]       wr_idx_i,
  input  logic [HANDLE_BITS-1:0] push_handle_i,
  input  logic [DELAY_W-1:0]     push_count_i,
  input  logic [HANDLE_BITS-1:0] nbr_handle_i,
  input  logic [DELAY_W-1:0]     nbr_count_i,
  output logic [HANDLE_BITS-1:0] handle_o,
  output logic [DELAY_W-1:0]     count_o
);

  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic [DELAY_W-1:0]     count_q, count_d;
  logic                   wr_here;

  assign wr_here = ctl_i.push && (wr_idx_i == IDX_W'(INDEX));

  always_comb begin
    handle_d = handle_q;
    count_d  = count_q;
    if (wr_here) begin
      handle_d = push_handle_i;
      count_d  = push_count_i;
    end else if (ctl_i.pop) begin
      handle_d = nbr_handle_i;
      count_d  = nbr_count_i;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    count_q  <= count_d;
  end

  assign handle_o = handle_q;
  assign count_o  = count_q;

endmodule

// File: hdl/dctt_ctrl.sv
// ----------------------------------------------------------------------------
// Timer table controller
// Walks the chain through its head cell once per scanning command, writes
// kept entries back at the tail, emits fired or refused handles in order.
// ----------------------------------------------------------------------------
module dctt_ctrl
  import dctt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned HANDLE_BITS = 16,
  parameter int unsigned IDX_W       = 6,
  parameter int unsigned CNT_W       = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  logic [ACTION_W-1:0]    action_i,
  input  logic [HANDLE_W-1:0]    handle_i,
  input  logic [DELAY_W-1:0]     delay_i,
  input  logic [HANDLE_BITS-1:0] hd_handle_i,
  input  logic [DELAY_W-1:0]     hd_count_i,
  output chain_ctl_t             ctl_o,
  output logic [IDX_W-1:0]       wr_idx_o,
  output logic [HANDLE_BITS-1:0] push_handle_o,
  output logic [DELAY_W-1:0]     push_count_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic                   m_kind_o,
  output logic [HANDLE_W-1:0]    m_handle_o,
  output logic                   m_last_o
);

  state_e                 state_q, state_d;
  action_e                act_q, act_d, in_act;
  logic [HANDLE_BITS-1:0] h_q, h_d, h_in;
  logic [DELAY_W-1:0]     dly_q, dly_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d, rem_q, rem_d;
  logic                   found_q, found_d;
  logic                   pend_v_q, pend_v_d;
  kind_e                  pend_kind_q, pend_kind_d;
  logic [HANDLE_BITS-1:0] pend_h_q, pend_h_d;
  logic                   out_v_q, out_v_d;
  kind_e                  out_kind_q, out_kind_d;
  logic [HANDLE_BITS-1:0] out_h_q, out_h_d;
  logic                   out_last_q, out_last_d;
  logic                   s_fire, out_free, in_scan, in_now, match;
  logic [DELAY_W-1:0]     dec;

  assign in_act   = action_e'(action_i);
  assign h_in     = HANDLE_BITS'(handle_i);
  assign s_ready_o = (state_q == ST_IDLE);
  assign s_fire   = s_valid_i && s_ready_o;
  assign out_free = !out_v_q || m_ready_i;
  assign in_now   = (in_act == ACT_ADD) && (h_in != '0) && (delay_i == '0);
  assign in_scan  = ((in_act == ACT_ADD) && (h_in != '0) && (delay_i != '0)) ||
                    ((in_act == ACT_REMOVE) && (h_in != '0)) ||
                    (in_act == ACT_TICK);
  assign match    = (hd_handle_i == h_q);
  assign dec      = hd_count_i - DELAY_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire && in_scan) begin
          state_d = ST_SCAN;
        end else if (s_fire && in_now) begin
          state_d = ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (rem_q == '0) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    act_d         = act_q;
    h_d           = h_q;
    dly_d         = dly_q;
    rem_d         = rem_q;
    found_d       = found_q;
    pend_v_d      = pend_v_q;
    pend_kind_d   = pend_kind_q;
    pend_h_d      = pend_h_q;
    ctl_o         = '0;
    push_handle_o = hd_handle_i;
    push_count_o  = hd_count_i;
    out_v_d       = out_v_q && !m_ready_i;
    out_kind_d    = out_kind_q;
    out_h_d       = out_h_q;
    out_last_d    = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          act_d   = in_act;
          h_d     = h_in;
          dly_d   = delay_i;
          rem_d   = cnt_q;
          found_d = 1'b0;
          if (in_now) begin
            pend_v_d    = 1'b1;
            pend_kind_d = KIND_FIRED;
            pend_h_d    = h_in;
          end
        end
      end
      ST_SCAN: begin
        if (rem_q != '0) begin
          if (out_free) begin
            ctl_o.pop = 1'b1;
            rem_d     = rem_q - CNT_W'(1);
            case (act_q)
              ACT_TICK: begin
                if (dec == '0) begin
                  if (pend_v_q) begin
                    out_v_d    = 1'b1;
                    out_kind_d = pend_kind_q;
                    out_h_d    = pend_h_q;
                    out_last_d = 1'b0;
                  end
                  pend_v_d    = 1'b1;
                  pend_kind_d = KIND_FIRED;
                  pend_h_d    = hd_handle_i;
                end else begin
                  ctl_o.push   = 1'b1;
                  push_count_o = dec;
                end
              end
              ACT_ADD: begin
                ctl_o.push = 1'b1;
                if (match) begin
                  push_count_o = dly_q;
                  found_d      = 1'b1;
                end
              end
              ACT_REMOVE: begin
                ctl_o.push = !match;
              end
              default: ctl_o = '0;
            endcase
          end
        end else if (act_q == ACT_ADD && !found_q) begin
          if (cnt_q < CNT_W'(TABLE_DEPTH)) begin
            ctl_o.push    = 1'b1;
            push_handle_o = h_q;
            push_count_o  = dly_q;
          end else begin
            pend_v_d    = 1'b1;
            pend_kind_d = KIND_FULL;
            pend_h_d    = h_q;
          end
        end
      end
      ST_FLUSH: begin
        if (pend_v_q && out_free) begin
          out_v_d    = 1'b1;
          out_kind_d = pend_kind_q;
          out_h_d    = pend_h_q;
          out_last_d = 1'b1;
          pend_v_d   = 1'b0;
        end
      end
      default: ctl_o = '0;
    endcase
  end

  always_comb begin
    cnt_d    = cnt_q + CNT_W'(ctl_o.push) - CNT_W'(ctl_o.pop);
    wr_idx_o = ctl_o.pop ? IDX_W'(cnt_q - CNT_W'(1)) : IDX_W'(cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    h_q         <= h_d;
    dly_q       <= dly_d;
    rem_q       <= rem_d;
    found_q     <= found_d;
    pend_kind_q <= pend_kind_d;
    pend_h_q    <= pend_h_d;
    out_kind_q  <= out_kind_d;
    out_h_q     <= out_h_d;
    out_last_q  <= out_last_d;
  end

  assign m_valid_o  = out_v_q;
  assign m_kind_o   = out_kind_q;
  assign m_handle_o = HANDLE_W'(out_h_q);
  assign m_last_o   = out_last_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.push && !ctl_o.pop) |-> (cnt_q < CNT_W'(TABLE_DEPTH)))
    else $error("Push into a full table.");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("Pending result left over while idle.");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rem_q <= cnt_q))
    else $error("Scan counter exceeds the entry count.");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_ready_i) |=> (out_v_q && $stable(out_h_q) && $stable(out_last_q)))
    else $error("Stalled result word was overwritten.");
`endif

endmodule

// File: hdl/delayed_call_timer_table_unit.sv
// ----------------------------------------------------------------------------
// Delayed call timer table unit
// Compacted table of pending (handle, countdown) timers built as a chain of
// entry cells, with add, remove and tick commands and in-order firing.
// ----------------------------------------------------------------------------
// The table is a row of TABLE_DEPTH cells that shifts one entry per cycle
// toward the head cell, unless the output word is held back by the consumer.
// A tick, a remove or an add with a nonzero delay looks at each stored entry
// in the head cell in table order and writes the kept ones back at the tail.
// Adds with handle zero, removes of handle zero and unknown actions are
// accepted and change nothing; an add with delay zero fires its handle
// without a walk of the table. A tick emits one word per fired entry in
// table order, the final one marked by tlast; tuser gives the kind (zero
// for a fired handle, one for an add refused because the table is full). No
// new word is accepted until the current command has finished its walk of
// the table.
module delayed_call_timer_table_unit
  import dctt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // action [1:0], handle [17:2], delay [33:18], zero fill [39:34]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // fired_handle [15:0]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // kind [0]
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  chain_ctl_t             ctl;
  logic [IDX_W-1:0]       wr_idx;
  logic [HANDLE_BITS-1:0] push_handle;
  logic [DELAY_W-1:0]     push_count;
  logic [HANDLE_BITS-1:0] cell_handle [TABLE_DEPTH];
  logic [DELAY_W-1:0]     cell_count  [TABLE_DEPTH];
  logic [HANDLE_W-1:0]    out_handle;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [HANDLE_BITS-1:0] nbr_handle;
    logic [DELAY_W-1:0]     nbr_count;

    if (i + 1 < TABLE_DEPTH) begin : g_mid
      assign nbr_handle = cell_handle[i+1];
      assign nbr_count  = cell_count[i+1];
    end else begin : g_end
      assign nbr_handle = '0;
      assign nbr_count  = '0;
    end

    dctt_cell #(
      .INDEX       (i),
      .IDX_W       (IDX_W),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .wr_idx_i      (wr_idx),
      .push_handle_i (push_handle),
      .push_count_i  (push_count),
      .nbr_handle_i  (nbr_handle),
      .nbr_count_i   (nbr_count),
      .handle_o      (cell_handle[i]),
      .count_o       (cell_count[i])
    );
  end

  dctt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_o     (s_axis_tready),
    .action_i      (s_axis_tdata[1:0]),
    .handle_i      (s_axis_tdata[17:2]),
    .delay_i       (s_axis_tdata[33:18]),
    .hd_handle_i   (cell_handle[0]),
    .hd_count_i    (cell_count[0]),
    .ctl_o         (ctl),
    .wr_idx_o      (wr_idx),
    .push_handle_o (push_handle),
    .push_count_o  (push_count),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_kind_o      (m_axis_tuser),
    .m_handle_o    (out_handle),
    .m_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = M_TDATA_W'(out_handle);

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Delayed call timer table unit testbench
// Drives add, remove and tick command words into the timer table and checks
// every fired or refused handle word against a predictor that keeps its own
// copy of the table or the directed row's word. Directed commands come first,
// then random commands, fill-ups to a full table and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import dctt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned LIMIT_CYCLES = 3000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned POOL_N = 12;
  localparam int unsigned RANDOM_PER_PHASE = 27;
  localparam int unsigned N_PLAN = 24;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    kind_e               kind;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } timer_word_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  delay;
    logic                typed;
    logic                has_word;
    kind_e               kind;
    logic [HANDLE_W-1:0] fired;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  logic [HANDLE_W-1:0] tbl_handle [TABLE_DEPTH];
  logic [DELAY_W-1:0]  tbl_countdown [TABLE_DEPTH];
  int unsigned         tbl_used = 0;

  timer_word_t         fired_now [$];
  timer_word_t         due_words [$];
  timer_word_t         head_word;
  logic [HANDLE_W-1:0] handle_pool [POOL_N];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          stall_req = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned full_seen = 0;
  int unsigned burst_max = 0;

  plan_row_t plan [N_PLAN] = '{
    '{ACT_TICK,   16'h0000, 16'h0000, 1'b1, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'h0000, 16'h0005, 1'b1, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'hFFFF, 16'h0000, 1'b1, 1'b1, KIND_FIRED, 16'hFFFF},
    '{ACT_ADD,    16'h0001, 16'h0000, 1'b1, 1'b1, KIND_FIRED, 16'h0001},
    '{ACT_REMOVE, 16'h0007, 16'h0000, 1'b1, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_REMOVE, 16'h0000, 16'hFFFF, 1'b1, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_UNUSED, 16'h0000, 16'h0000, 1'b1, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'h0001, 16'h0001, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'hFFFF, 16'hFFFF, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'h8000, 16'h0002, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'h0001, 16'h0003, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'h0001, 16'h0000, 1'b1, 1'b1, KIND_FIRED, 16'h0001},
    '{ACT_TICK,   16'h0000, 16'h0000, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_TICK,   16'hFFFF, 16'hFFFF, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_REMOVE, 16'hFFFF, 16'h0000, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_REMOVE, 16'hFFFF, 16'h0000, 1'b1, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'h5555, 16'hAAAA, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'h5555, 16'h0001, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'hAAAA, 16'h5555, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_ADD,    16'h2222, 16'h0001, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_TICK,   16'h0000, 16'h0000, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_REMOVE, 16'hAAAA, 16'h0000, 1'b0, 1'b0, KIND_FIRED, 16'h0000},
    '{ACT_TICK,   16'h0000, 16'h0000, 1'b1, 1'b0, KIND_FIRED, 16'h0000}
  };

  delayed_call_timer_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .HANDLE_BITS(HANDLE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int slot_of(input logic [HANDLE_W-1:0] h);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_handle[i] == h) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(input int unsigned slot);
    for (int unsigned i = slot; i + 1 < tbl_used; i++) begin
      tbl_handle[i]    = tbl_handle[i + 1];
      tbl_countdown[i] = tbl_countdown[i + 1];
    end
    tbl_used--;
  endfunction

  // Applies one command word to the model table and leaves the words it
  // causes in fired_now, in output order.
  function automatic void timer_table_apply(input logic [ACTION_W-1:0] act,
                                            input logic [HANDLE_W-1:0] h,
                                            input logic [DELAY_W-1:0] d);
    int slot;
    int unsigned pos;
    fired_now.delete();
    if (act == ACT_ADD) begin
      if (h != '0) begin
        if (d == '0) begin
          fired_now.push_back('{KIND_FIRED, h, 1'b0});
        end else begin
          slot = slot_of(h);
          if (slot >= 0) begin
            tbl_countdown[slot] = d;
          end else if (tbl_used < TABLE_DEPTH) begin
            tbl_handle[tbl_used]    = h;
            tbl_countdown[tbl_used] = d;
            tbl_used++;
          end else begin
            fired_now.push_back('{KIND_FULL, h, 1'b0});
          end
        end
      end
    end else if (act == ACT_REMOVE) begin
      if (h != '0) begin
        slot = slot_of(h);
        if (slot >= 0) drop_slot(slot);
      end
    end else if (act == ACT_TICK) begin
      pos = 0;
      while (pos < tbl_used) begin
        tbl_countdown[pos] = tbl_countdown[pos] - 1'b1;
        if (tbl_countdown[pos] == '0) begin
          fired_now.push_back('{KIND_FIRED, tbl_handle[pos], 1'b0});
          drop_slot(pos);
        end else begin
          pos++;
        end
      end
    end
    if (fired_now.size() > 0) fired_now[fired_now.size() - 1].last = 1'b1;
  endfunction

  task automatic send_word(input logic [ACTION_W-1:0] act,
                           input logic [HANDLE_W-1:0] h,
                           input logic [DELAY_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, d, h, act};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic issue(input logic [ACTION_W-1:0] act,
                       input logic [HANDLE_W-1:0] h,
                       input logic [DELAY_W-1:0] d);
    send_word(act, h, d);
    timer_table_apply(act, h, d);
    foreach (fired_now[i]) begin
      due_words.push_back(fired_now[i]);
      if (fired_now[i].kind == KIND_FULL) full_seen++;
    end
    if (act == ACT_TICK && fired_now.size() > burst_max) burst_max = fired_now.size();
  endtask

  task automatic random_word();
    int unsigned pick;
    logic [ACTION_W-1:0] act;
    logic [HANDLE_W-1:0] h;
    logic [DELAY_W-1:0] d;
    pick = $urandom_range(99);
    h = handle_pool[$urandom_range(POOL_N - 1)];
    if ($urandom_range(4) == 0) h = HANDLE_W'($urandom);
    d = DELAY_W'($urandom_range(1, 6));
    if (pick < 45) begin
      act = ACT_ADD;
      case ($urandom_range(19))
        0, 1: d = '0;
        2: d = DELAY_W'($urandom);
        default: ;
      endcase
    end else if (pick < 60) begin
      act = ACT_REMOVE;
      if (tbl_used > 0 && $urandom_range(1) == 1) h = tbl_handle[$urandom_range(tbl_used - 1)];
    end else if (pick < 90) begin
      act = ACT_TICK;
      d = DELAY_W'($urandom);
    end else if (pick < 95) begin
      act = ACT_ADD;
      h = '0;
    end else begin
      act = ACT_UNUSED;
      h = HANDLE_W'($urandom);
      d = DELAY_W'($urandom);
    end
    issue(act, h, d);
  endtask

  // Fills every slot, offers two more random handles and ticks; with
  // hold_output the tick bursts into a long receiver hold-off.
  task automatic fill_table(input bit hold_output);
    logic [HANDLE_W-1:0] h;
    while (tbl_used < TABLE_DEPTH) begin
      h = HANDLE_W'($urandom_range(1, 65535));
      if (slot_of(h) < 0) begin
        issue(ACT_ADD, h, hold_output ? DELAY_W'(1) : DELAY_W'($urandom_range(1, 3)));
      end
    end
    repeat (2) issue(ACT_ADD, HANDLE_W'($urandom_range(1, 65535)), DELAY_W'(7));
    if (hold_output) stall_req = 1'b1;
    issue(ACT_TICK, '0, '0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_words.size() == 0) begin
        errors++;
        $error("unexpected word: kind %0d handle 0x%04h last %0d",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        head_word = due_words.pop_front();
        words_checked++;
        if (m_axis_tuser !== head_word.kind) begin
          errors++;
          $error("kind: expected %0d, got %0d", head_word.kind, m_axis_tuser);
        end
        if (m_axis_tdata !== head_word.handle) begin
          errors++;
          $error("fired_handle: expected 0x%04h, got 0x%04h", head_word.handle, m_axis_tdata);
        end
        if (m_axis_tlast !== head_word.last) begin
          errors++;
          $error("last: expected %0d, got %0d", head_word.last, m_axis_tlast);
        end
      end
    end
    if (stall_req) begin
      stall_left = HOLD_CYCLES;
      stall_req  = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    for (int i = 0; i < POOL_N; i++) handle_pool[i] = HANDLE_W'($urandom_range(1, 65535));
    send_idle_pct = 28;
    recv_idle_pct = 67;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_PLAN; i++) begin
      if (plan[i].typed) begin
        send_word(plan[i].act, plan[i].handle, plan[i].delay);
        timer_table_apply(plan[i].act, plan[i].handle, plan[i].delay);
        if (plan[i].has_word) due_words.push_back('{plan[i].kind, plan[i].fired, 1'b1});
      end else begin
        issue(plan[i].act, plan[i].handle, plan[i].delay);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 67;
          fill_table(1'b1);
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          fill_table(1'b0);
        end
      endcase
      repeat (RANDOM_PER_PHASE) random_word();
    end

    s_axis_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);

    $display("Sent %0d command words; %0d table-full refusals, largest tick burst %0d words.",
             words_sent, full_seen, burst_max);
    $display("Checked %0d result words against the timer table predictor.", words_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
